/* hw/rtl/dpnf_pkg.sv */
// ----------------------------------------------------------------------------
// Dead pixel neighbour fill: shared definitions
// Request and result types, opcodes, register indexes and size defaults.
// ----------------------------------------------------------------------------
package dpnf_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int DIM_W = 7;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_REPAIR = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_IMAGE_ROWS = 1'b0,
		REG_IMAGE_COLS = 1'b1
	} reg_index_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
	} request_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [11:0] pass_count;
	} result_t;

endpackage

/* hw/rtl/dead_pixel_neighbor_fill.sv */
// ----------------------------------------------------------------------------
// Dead pixel neighbour fill
// Holds an RGB image in two banks and repairs dead pixels by the rounded-up
// mean of their live four neighbours, pass after pass until nothing changes.
//
//   channel   ports                          direction  handshake
//   request   start, busy, request           in         start & !busy
//   result    done, result                   out        done, one cycle
//   config    cfg_we, cfg_idx, cfg_data      in         cfg_we
//
// Write, read and unused requests are taken at once; the result follows on the
// next cycle and a new request may be taken at once.
// A repair request walks the image once per pass through one memory read
// port: a live pixel goes through S_CTR and S_CHK, a dead one also through
// S_NB for each of its four neighbours and S_DIV; every pass ends in S_END.
// The two banks swap roles after every pass that changed a pixel.
// Reset clears only control state and the registers; the image is undefined.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module dead_pixel_neighbor_fill #(
	parameter int MAX_ROWS = dpnf_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = dpnf_pkg::DEF_MAX_COLS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  dpnf_pkg::request_t                request,
	output logic                              done,
	output dpnf_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  dpnf_pkg::reg_index_t              cfg_idx,
	input  logic [dpnf_pkg::DIM_W-1:0]        cfg_data
);
	import dpnf_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DRW   = $clog2(MAX_ROWS + 1);
	localparam int DCW   = $clog2(MAX_COLS + 1);

	localparam logic [1:0] NB_UP    = 2'd0;
	localparam logic [1:0] NB_DOWN  = 2'd1;
	localparam logic [1:0] NB_LEFT  = 2'd2;
	localparam logic [1:0] NB_RIGHT = 2'd3;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CTR  = 6'b000010,
		S_CHK  = 6'b000100,
		S_NB   = 6'b001000,
		S_DIV  = 6'b010000,
		S_END  = 6'b100000
	} state_t;

	logic [23:0] bank0_mem [DEPTH];
	logic [23:0] bank1_mem [DEPTH];
	logic [23:0] rd0_q;
	logic [23:0] rd1_q;

	state_t           state_q;
	logic [DIM_W-1:0] rows_cfg_q;
	logic [DIM_W-1:0] cols_cfg_q;
	logic             cur_q;
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic [AW-1:0]    idx_q;
	logic [1:0]       k_q;
	logic [9:0]       sum_r_q;
	logic [9:0]       sum_g_q;
	logic [9:0]       sum_b_q;
	logic [2:0]       cnt_q;
	logic             changed_q;
	logic [11:0]      passes_q;
	logic             done_q;
	logic             pix_sel_q;
	logic [11:0]      res_pass_q;

	logic [DRW-1:0]   rows_eff;
	logic [DCW-1:0]   cols_eff;
	logic             accept;
	logic             req_inside;
	logic [AW-1:0]    req_addr;
	logic [AW-1:0]    ctr_addr;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic             wr_bank;
	logic [AW-1:0]    wr_addr;
	logic [23:0]      wr_data;
	logic [23:0]      pix;
	logic             last_row;
	logic             last_col;
	logic             nb_ok;
	logic [23:0]      fill_pix;

	function automatic logic [7:0] ceil_div(input logic [9:0] s, input logic [2:0] n);
		logic [9:0]  x;
		logic [20:0] p;
		x = s + 10'(n) - 10'd1;
		p = 21'(x) * 21'd683;
		unique case (n)
			3'd1:    ceil_div = x[7:0];
			3'd2:    ceil_div = x[8:1];
			3'd3:    ceil_div = p[18:11];
			default: ceil_div = x[9:2];
		endcase
	endfunction

	function automatic logic [AW-1:0] nb_addr(input logic [AW-1:0] idx, input logic [1:0] k);
		unique case (k)
			NB_UP:    nb_addr = idx - AW'(MAX_COLS);
			NB_DOWN:  nb_addr = idx + AW'(MAX_COLS);
			NB_LEFT:  nb_addr = idx - AW'(1);
			default:  nb_addr = idx + AW'(1);
		endcase
	endfunction

	always_comb begin
		if (rows_cfg_q == '0) begin
			rows_eff = DRW'(1);
		end else if (32'(rows_cfg_q) > MAX_ROWS) begin
			rows_eff = DRW'(MAX_ROWS);
		end else begin
			rows_eff = DRW'(rows_cfg_q);
		end
		if (cols_cfg_q == '0) begin
			cols_eff = DCW'(1);
		end else if (32'(cols_cfg_q) > MAX_COLS) begin
			cols_eff = DCW'(MAX_COLS);
		end else begin
			cols_eff = DCW'(cols_cfg_q);
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign req_inside = (32'(request.row) < 32'(rows_eff)) &&
	                    (32'(request.col) < 32'(cols_eff));
	assign req_addr   = AW'(32'(request.row) * MAX_COLS + 32'(request.col));
	assign ctr_addr   = AW'(32'(r_q) * MAX_COLS + 32'(c_q));
	assign pix        = cur_q ? rd1_q : rd0_q;
	assign last_row   = (DRW'(r_q) == rows_eff - DRW'(1));
	assign last_col   = (DCW'(c_q) == cols_eff - DCW'(1));

	always_comb begin
		unique case (k_q)
			NB_UP:    nb_ok = (r_q != '0);
			NB_DOWN:  nb_ok = !last_row;
			NB_LEFT:  nb_ok = (c_q != '0);
			default:  nb_ok = !last_col;
		endcase
	end

	assign fill_pix = (cnt_q == '0) ? 24'd0 :
	                  {ceil_div(sum_r_q, cnt_q), ceil_div(sum_g_q, cnt_q),
	                   ceil_div(sum_b_q, cnt_q)};

	always_comb begin
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_bank = !cur_q;
		wr_addr = idx_q;
		wr_data = pix;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = req_addr;
				wr_en   = accept && (request.opcode == OP_WRITE) && req_inside;
				wr_bank = cur_q;
				wr_addr = req_addr;
				wr_data = {request.red_in, request.green_in, request.blue_in};
			end
			S_CTR: begin
				rd_addr = ctr_addr;
			end
			S_CHK: begin
				rd_addr = nb_addr(idx_q, k_q);
				wr_en   = (pix != '0);
			end
			S_NB: begin
				rd_addr = nb_addr(idx_q, k_q + 2'd1);
			end
			S_DIV: begin
				wr_en   = 1'b1;
				wr_data = fill_pix;
			end
			default: begin
				rd_addr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			bank0_mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_bank) begin
			bank1_mem[wr_addr] <= wr_data;
		end
		rd0_q <= bank0_mem[rd_addr];
		rd1_q <= bank1_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= DIM_RESET;
			cols_cfg_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_ROWS: rows_cfg_q <= cfg_data;
				REG_IMAGE_COLS: cols_cfg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= 1'b0;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			changed_q  <= 1'b0;
			passes_q   <= '0;
			done_q     <= 1'b0;
			pix_sel_q  <= 1'b0;
			res_pass_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (request.opcode == OP_REPAIR) begin
							r_q       <= '0;
							c_q       <= '0;
							changed_q <= 1'b0;
							passes_q  <= '0;
							state_q   <= S_CTR;
						end else begin
							done_q     <= 1'b1;
							pix_sel_q  <= (request.opcode == OP_READ) && req_inside;
							res_pass_q <= '0;
						end
					end
				end
				S_CTR: begin
					k_q     <= NB_UP;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (pix == '0) begin
						state_q <= S_NB;
					end else if (last_col) begin
						c_q     <= '0;
						r_q     <= last_row ? '0 : r_q + RW'(1);
						state_q <= last_row ? S_END : S_CTR;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_CTR;
					end
				end
				S_NB: begin
					k_q <= k_q + 2'd1;
					if (k_q == NB_RIGHT) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q != '0) begin
						changed_q <= 1'b1;
					end
					if (last_col) begin
						c_q     <= '0;
						r_q     <= last_row ? '0 : r_q + RW'(1);
						state_q <= last_row ? S_END : S_CTR;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_CTR;
					end
				end
				S_END: begin
					if (changed_q) begin
						if (passes_q != '1) begin
							passes_q <= passes_q + 12'd1;
						end
						cur_q     <= !cur_q;
						changed_q <= 1'b0;
						state_q   <= S_CTR;
					end else begin
						done_q     <= 1'b1;
						pix_sel_q  <= 1'b0;
						res_pass_q <= passes_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CTR) begin
			idx_q <= ctr_addr;
		end
		if (state_q == S_CHK) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q   <= '0;
		end else if ((state_q == S_NB) && nb_ok && (pix != '0)) begin
			sum_r_q <= sum_r_q + 10'(pix[23:16]);
			sum_g_q <= sum_g_q + 10'(pix[15:8]);
			sum_b_q <= sum_b_q + 10'(pix[7:0]);
			cnt_q   <= cnt_q + 3'd1;
		end
	end

	assign done              = done_q;
	assign result.red_out    = pix_sel_q ? pix[23:16] : 8'd0;
	assign result.green_out  = pix_sel_q ? pix[15:8] : 8'd0;
	assign result.blue_out   = pix_sel_q ? pix[7:0] : 8'd0;
	assign result.pass_count = res_pass_q;

`ifndef ASSERT_OFF
	a_repair_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (request.opcode == OP_REPAIR)) |=> busy)
		else $error("repair request did not start the sequencer");

	a_pass_writes_other_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q != S_IDLE)) |-> (wr_bank != cur_q))
		else $error("pass wrote into the bank it reads from");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= 3'd4))
		else $error("live neighbour count above four");

	a_pass_count_source: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.pass_count != '0)) |-> $past(state_q == S_END))
		else $error("pass count reported outside a repair");
`endif

endmodule
